FILE: rtl/pdrdc_pkg.sv
// ----------------------------------------------------------------------------
// pdrdc_pkg
// shared types and codes of the pdu receive deframer and digest checker
// ----------------------------------------------------------------------------
package pdrdc_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 24;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HDR_BAD  = 3'd1;
  localparam logic [2:0] ST_DATA_BAD = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_CLOSED   = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       peer_closed;
  } rx_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [1:0]       byte_kind;
    logic             unit_end;
    logic [2:0]       status;
    logic [LEN_W-1:0] segment_len;
  } tx_item_t;

endpackage

FILE: rtl/pdrdc_stream_if.sv
// ----------------------------------------------------------------------------
// pdrdc_stream_if
// valid/ready stream channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface pdrdc_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/pdu_receive_deframer_checker_unit.sv
// ----------------------------------------------------------------------------
// pdu_receive_deframer_checker_unit
// splits a received byte stream into pdus and checks crc-32c digests
// ----------------------------------------------------------------------------
// din carries one stream byte (or a peer-closed flag) per transfer. dout
// carries at most one result per input transfer: header and data bytes as
// they arrive, and a status-only or last-byte result that ends each unit.
// pad and digest bytes produce no result. the apb port sets the header and
// data digest enables and the largest accepted segment length; write it
// only while the block is idle.
// each result is registered into the output register (or the skid register
// when dout stalls). one input is taken every cycle while the skid register
// is empty: the frame state and the bytewise crc update sit between the
// state registers and a two-entry output buffer (output register plus skid
// register), so din keeps flowing while one result waits on dout. when dout
// stalls, the skid register fills and din.ready drops until dout takes a result.
// reset (rst, synchronous) empties the output buffer, returns the frame
// logic to the start of a header and loads the register defaults.
// ----------------------------------------------------------------------------
module pdu_receive_deframer_checker_unit
  import pdrdc_pkg::*;
#(
  parameter int HEADER_BYTES = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  pdrdc_stream_if.sink      din,
  pdrdc_stream_if.source    dout
);

  localparam logic [1:0]       REG_HDR_DIGEST = 2'd0;
  localparam logic [1:0]       REG_DATA_DIGEST = 2'd1;
  localparam logic [1:0]       REG_MAX_LEN    = 2'd2;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET  = 24'd262144;
  localparam logic [LEN_W-1:0] HDR_LAST       = LEN_W'(HEADER_BYTES - 1);
  localparam logic [31:0]      CRC_POLY       = 32'h82F63B78;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_HDIGEST,
    PH_DATA,
    PH_DDIGEST
  } phase_t;

  function automatic logic [31:0] crc_step(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic tx_item_t mk_res(input logic [7:0] b, input logic [1:0] kind,
                                      input logic last, input logic [2:0] st,
                                      input logic [LEN_W-1:0] len);
    tx_item_t r;
    r.out_byte    = b;
    r.byte_kind   = kind;
    r.unit_end    = last;
    r.status      = last ? st : ST_OK;
    r.segment_len = last ? len : '0;
    return r;
  endfunction

  // configuration
  logic             hdr_digest_on;
  logic             data_digest_on;
  logic [LEN_W-1:0] max_segment_len;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  // frame state
  phase_t           phase, phase_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [31:0]      crc, crc_next;
  logic [LEN_W-1:0] data_length, data_length_next;
  logic [31:0]      received_digest, received_digest_next;

  // output buffer
  logic     out_valid;
  tx_item_t out_reg;
  logic     skid_valid;
  tx_item_t skid;

  logic             accept;
  logic             take;
  logic             res_valid;
  tx_item_t         res;
  logic [7:0]       b;
  logic [31:0]      crc_upd;
  logic [31:0]      dig_shift;
  logic [LEN_W:0]   padded;
  logic [LEN_W:0]   cnt_inc;
  logic [LEN_W-1:0] len_cur;
  logic             hdr_fin;
  logic [1:0]       fin_kind;
  logic [7:0]       fin_byte;
  logic             is_data;
  logic             go_idle;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_HDR_DIGEST:  prdata = {31'd0, hdr_digest_on};
      REG_DATA_DIGEST: prdata = {31'd0, data_digest_on};
      REG_MAX_LEN:     prdata = {8'd0, max_segment_len};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_digest_on   <= 1'b0;
      data_digest_on  <= 1'b0;
      max_segment_len <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HDR_DIGEST:  hdr_digest_on   <= pwdata[0];
        REG_DATA_DIGEST: data_digest_on  <= pwdata[0];
        REG_MAX_LEN:     max_segment_len <= pwdata[LEN_W-1:0];
        default:         ;
      endcase
    end
  end

  assign din.ready = !skid_valid;
  assign accept    = din.valid && din.ready;
  assign take      = dout.valid && dout.ready;
  assign b         = din.data.rx_byte;
  assign crc_upd   = crc_step(crc, b);
  assign dig_shift = {received_digest[23:0], b};
  assign padded    = ({1'b0, data_length} + (LEN_W+1)'(3)) & ~(LEN_W+1)'(3);
  assign cnt_inc   = {1'b0, byte_count} + (LEN_W+1)'(1);
  assign is_data   = byte_count < data_length;

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    crc_next             = crc;
    data_length_next     = data_length;
    received_digest_next = received_digest;
    res_valid            = 1'b0;
    res                  = '0;
    len_cur              = data_length;
    hdr_fin              = 1'b0;
    fin_kind             = KIND_NONE;
    fin_byte             = 8'd0;
    go_idle              = 1'b0;

    if (accept) begin
      if (din.data.peer_closed) begin
        res_valid = 1'b1;
        res       = mk_res(8'd0, KIND_NONE, 1'b1, ST_CLOSED, data_length);
        go_idle   = 1'b1;
      end else begin
        unique case (phase)
          PH_HEADER: begin
            crc_next = crc_upd;
            if (byte_count >= LEN_W'(5) && byte_count <= LEN_W'(7)) begin
              len_cur = {data_length[15:0], b};
            end
            data_length_next = len_cur;
            if (byte_count == HDR_LAST) begin
              byte_count_next = '0;
              if (hdr_digest_on) begin
                phase_next           = PH_HDIGEST;
                received_digest_next = '0;
                res_valid            = 1'b1;
                res = mk_res(b, KIND_HEADER, 1'b0, ST_OK, len_cur);
              end else begin
                hdr_fin  = 1'b1;
                fin_kind = KIND_HEADER;
                fin_byte = b;
              end
            end else begin
              byte_count_next = cnt_inc[LEN_W-1:0];
              res_valid       = 1'b1;
              res = mk_res(b, KIND_HEADER, 1'b0, ST_OK, len_cur);
            end
          end
          PH_HDIGEST: begin
            received_digest_next = dig_shift;
            if (byte_count >= LEN_W'(3)) begin
              byte_count_next = '0;
              if (dig_shift != ~crc) begin
                res_valid = 1'b1;
                res       = mk_res(8'd0, KIND_NONE, 1'b1, ST_HDR_BAD, data_length);
                go_idle   = 1'b1;
              end else begin
                hdr_fin = 1'b1;
              end
            end else begin
              byte_count_next = cnt_inc[LEN_W-1:0];
            end
          end
          PH_DATA: begin
            crc_next = crc_upd;
            if (cnt_inc >= padded) begin
              byte_count_next = '0;
              if (data_digest_on) begin
                phase_next           = PH_DDIGEST;
                received_digest_next = '0;
                res_valid            = is_data;
                res = mk_res(b, KIND_DATA, 1'b0, ST_OK, data_length);
              end else begin
                res_valid = 1'b1;
                res = is_data ? mk_res(b, KIND_DATA, 1'b1, ST_OK, data_length)
                              : mk_res(8'd0, KIND_NONE, 1'b1, ST_OK, data_length);
                go_idle = 1'b1;
              end
            end else begin
              byte_count_next = cnt_inc[LEN_W-1:0];
              res_valid       = is_data;
              res = mk_res(b, KIND_DATA, 1'b0, ST_OK, data_length);
            end
          end
          PH_DDIGEST: begin
            received_digest_next = dig_shift;
            if (byte_count >= LEN_W'(3)) begin
              res_valid = 1'b1;
              res = mk_res(8'd0, KIND_NONE, 1'b1,
                           (dig_shift == ~crc) ? ST_OK : ST_DATA_BAD, data_length);
              go_idle = 1'b1;
            end else begin
              byte_count_next = cnt_inc[LEN_W-1:0];
            end
          end
        endcase

        // header and optional header digest complete
        if (hdr_fin) begin
          if (len_cur == '0) begin
            res_valid = 1'b1;
            res       = mk_res(fin_byte, fin_kind, 1'b1, ST_OK, len_cur);
            go_idle   = 1'b1;
          end else if (len_cur > max_segment_len) begin
            res_valid = 1'b1;
            res       = mk_res(fin_byte, fin_kind, 1'b1, ST_TOO_LONG, len_cur);
            go_idle   = 1'b1;
          end else begin
            phase_next      = PH_DATA;
            byte_count_next = '0;
            crc_next        = '1;
            res_valid       = (fin_kind == KIND_HEADER);
            res = mk_res(fin_byte, KIND_HEADER, 1'b0, ST_OK, len_cur);
          end
        end
      end

      if (go_idle) begin
        phase_next           = PH_HEADER;
        byte_count_next      = '0;
        crc_next             = '1;
        data_length_next     = '0;
        received_digest_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_count      <= '0;
      crc             <= '1;
      data_length     <= '0;
      received_digest <= '0;
    end else begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      crc             <= crc_next;
      data_length     <= data_length_next;
      received_digest <= received_digest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_reg    <= skid;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_reg   <= res;
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid       <= res;
      skid_valid <= 1'b1;
    end
  end

  assign dout.valid = out_valid;
  assign dout.data  = out_reg;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  a_mid_unit_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reg.unit_end) |-> (out_reg.status == ST_OK && out_reg.segment_len == '0))
    else $error("status or length set on a result that does not end a unit");

  a_status_only_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.byte_kind == KIND_NONE) |-> (out_reg.unit_end && out_reg.out_byte == 8'd0))
    else $error("status-only result does not end a unit");

  a_data_needs_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (data_length != '0))
    else $error("data phase entered with an empty segment");

  a_close_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && din.data.peer_closed) |=> (phase == PH_HEADER && byte_count == '0))
    else $error("peer close did not return to the header phase");

endmodule

FILE: sim/tb_pdu_receive_deframer_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_pdu_receive_deframer_checker_unit
// self-checking bench for the pdu receive deframer and crc-32c digest checker
// ----------------------------------------------------------------------------
// builds pdus (header, optional header digest, padded data, optional data
// digest) with correct or corrupted digests, truncated units cut by a peer
// close, lone closes and over-long segments. a byte-level model of the
// deframer predicts every result from the accepted transfers, and the
// monitor compares each result field by field. the run steps through six
// register settings and three stall profiles on both stream sides.
// ----------------------------------------------------------------------------
module tb_pdu_receive_deframer_checker_unit
  import pdrdc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR_BYTES = 48;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;

  localparam logic [ADDR_W-1:0] ADDR_HDR_DIGEST = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_DATA_DIGEST = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_MAX_SEG = 4'h8;

  typedef enum logic [1:0] {
    FR_HEADER,
    FR_HDIGEST,
    FR_DATA,
    FR_DDIGEST
  } frame_phase_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  pdrdc_stream_if #(.T(rx_item_t)) rx_if ();
  pdrdc_stream_if #(.T(tx_item_t)) tx_if ();

  pdu_receive_deframer_checker_unit #(
    .HEADER_BYTES(HDR_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .din(rx_if),
    .dout(tx_if)
  );

  // register copies seen by the deframer model and the stream builder
  bit hdig_on;
  bit ddig_on;
  logic [LEN_W-1:0] seg_max;

  // deframer model state
  frame_phase_t fr_phase;
  logic [LEN_W-1:0] fr_count;
  logic [31:0] fr_crc;
  logic [LEN_W-1:0] fr_len;
  logic [31:0] fr_digest;

  rx_item_t rx_stream[$];
  tx_item_t due_results[$];
  int queued_items;
  int mismatches;
  int cycles;
  int src_idle;
  int snk_idle;
  bit rx_taken;
  tx_item_t got_res;
  tx_item_t want_res;
  tx_item_t next_res;

  function automatic logic [31:0] crc32c_byte(logic [31:0] c, logic [7:0] b);
    c ^= {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void frame_restart();
    fr_phase = FR_HEADER;
    fr_count = '0;
    fr_crc = '1;
    fr_len = '0;
    fr_digest = '0;
  endfunction

  function automatic tx_item_t pack_result(logic [7:0] b, logic [1:0] kind, logic last,
                                           logic [2:0] st);
    tx_item_t r;
    r.out_byte = b;
    r.byte_kind = kind;
    r.unit_end = last;
    r.status = last ? st : ST_OK;
    r.segment_len = last ? fr_len : '0;
    return r;
  endfunction

  function automatic bit header_complete(logic [7:0] b, logic [1:0] kind, output tx_item_t r);
    if (fr_len == 0) begin
      r = pack_result(b, kind, 1'b1, ST_OK);
      frame_restart();
      return 1'b1;
    end
    if (fr_len > seg_max) begin
      r = pack_result(b, kind, 1'b1, ST_TOO_LONG);
      frame_restart();
      return 1'b1;
    end
    fr_phase = FR_DATA;
    fr_count = '0;
    fr_crc = '1;
    r = pack_result(b, KIND_HEADER, 1'b0, ST_OK);
    return kind == KIND_HEADER;
  endfunction

  function automatic bit deframe_byte(rx_item_t it, output tx_item_t r);
    logic [31:0] padded;
    bit is_data;
    bit last_byte;
    r = '0;
    if (it.peer_closed) begin
      r = pack_result(8'h00, KIND_NONE, 1'b1, ST_CLOSED);
      frame_restart();
      return 1'b1;
    end
    case (fr_phase)
      FR_HEADER: begin
        fr_crc = crc32c_byte(fr_crc, it.rx_byte);
        if (fr_count >= 5 && fr_count <= 7) fr_len = {fr_len[15:0], it.rx_byte};
        if (fr_count + 1 >= HDR_BYTES) begin
          fr_count = '0;
          if (hdig_on) begin
            fr_phase = FR_HDIGEST;
            fr_digest = '0;
            r = pack_result(it.rx_byte, KIND_HEADER, 1'b0, ST_OK);
            return 1'b1;
          end
          return header_complete(it.rx_byte, KIND_HEADER, r);
        end
        fr_count++;
        r = pack_result(it.rx_byte, KIND_HEADER, 1'b0, ST_OK);
        return 1'b1;
      end
      FR_HDIGEST: begin
        fr_digest = {fr_digest[23:0], it.rx_byte};
        if (fr_count >= 3) begin
          fr_count = '0;
          if (fr_digest != ~fr_crc) begin
            r = pack_result(8'h00, KIND_NONE, 1'b1, ST_HDR_BAD);
            frame_restart();
            return 1'b1;
          end
          return header_complete(8'h00, KIND_NONE, r);
        end
        fr_count++;
        return 1'b0;
      end
      FR_DATA: begin
        fr_crc = crc32c_byte(fr_crc, it.rx_byte);
        padded = ({8'd0, fr_len} + 32'd3) & ~32'd3;
        is_data = fr_count < fr_len;
        last_byte = {8'd0, fr_count} + 32'd1 >= padded;
        if (last_byte) begin
          fr_count = '0;
          if (ddig_on) begin
            fr_phase = FR_DDIGEST;
            fr_digest = '0;
            r = pack_result(it.rx_byte, KIND_DATA, 1'b0, ST_OK);
            return is_data;
          end
          if (is_data) r = pack_result(it.rx_byte, KIND_DATA, 1'b1, ST_OK);
          else r = pack_result(8'h00, KIND_NONE, 1'b1, ST_OK);
          frame_restart();
          return 1'b1;
        end
        fr_count++;
        r = pack_result(it.rx_byte, KIND_DATA, 1'b0, ST_OK);
        return is_data;
      end
      FR_DDIGEST: begin
        fr_digest = {fr_digest[23:0], it.rx_byte};
        if (fr_count >= 3) begin
          r = pack_result(8'h00, KIND_NONE, 1'b1,
                          (fr_digest == ~fr_crc) ? ST_OK : ST_DATA_BAD);
          frame_restart();
          return 1'b1;
        end
        fr_count++;
        return 1'b0;
      end
      default: begin
        frame_restart();
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_close();
    rx_item_t it;
    it.rx_byte = 8'($urandom);
    it.peer_closed = 1'b1;
    rx_stream.push_back(it);
    queued_items++;
  endtask

  // one pdu; a truncated unit stops at a random byte and ends with a close
  task automatic queue_unit(input logic [LEN_W-1:0] seg_len, input bit bad_hdr,
                            input bit bad_dat, input bit truncate);
    rx_item_t unit_q[$];
    rx_item_t it;
    logic [31:0] crc;
    logic [31:0] dig;
    logic [7:0] b;
    int padded;
    int keep;
    crc = '1;
    it.peer_closed = 1'b0;
    for (int i = 0; i < HDR_BYTES; i++) begin
      b = 8'($urandom);
      if (i == 5) b = seg_len[23:16];
      if (i == 6) b = seg_len[15:8];
      if (i == 7) b = seg_len[7:0];
      crc = crc32c_byte(crc, b);
      it.rx_byte = b;
      unit_q.push_back(it);
    end
    if (hdig_on) begin
      dig = ~crc;
      if (bad_hdr) dig ^= 32'h1 << $urandom_range(31);
      for (int i = 3; i >= 0; i--) begin
        it.rx_byte = dig[8*i +: 8];
        unit_q.push_back(it);
      end
    end
    if (!(hdig_on && bad_hdr) && seg_len != 0 && seg_len <= seg_max) begin
      crc = '1;
      padded = (int'(seg_len) + 3) & ~3;
      for (int i = 0; i < padded; i++) begin
        b = 8'($urandom);
        crc = crc32c_byte(crc, b);
        it.rx_byte = b;
        unit_q.push_back(it);
      end
      if (ddig_on) begin
        dig = ~crc;
        if (bad_dat) dig ^= 32'h1 << $urandom_range(31);
        for (int i = 3; i >= 0; i--) begin
          it.rx_byte = dig[8*i +: 8];
          unit_q.push_back(it);
        end
      end
    end
    keep = truncate ? $urandom_range(unit_q.size() - 1) : unit_q.size();
    for (int i = 0; i < keep; i++) rx_stream.push_back(unit_q[i]);
    queued_items += keep;
    if (truncate) push_close();
  endtask

  function automatic logic [LEN_W-1:0] short_len();
    if ($urandom_range(3) != 0) return LEN_W'($urandom_range(12));
    return LEN_W'($urandom_range(64, 13));
  endfunction

  task automatic queue_random_unit();
    int sel;
    logic [LEN_W-1:0] len;
    sel = $urandom_range(99);
    if (sel < 65) begin
      queue_unit(short_len(), $urandom_range(9) == 0, $urandom_range(9) == 0, 1'b0);
    end else if (sel < 80) begin
      queue_unit(short_len(), 1'b0, 1'b0, 1'b1);
    end else if (sel < 92) begin
      if (seg_max < 24'hFFFFFF && $urandom_range(1) == 1)
        len = LEN_W'($urandom_range(32'hFFFFFF, int'(seg_max) + 1));
      else if (seg_max <= 64)
        len = seg_max;
      else
        len = LEN_W'($urandom_range(64));
      queue_unit(len, 1'b0, 1'b0, 1'b0);
    end else begin
      push_close();
    end
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      ADDR_HDR_DIGEST: hdig_on = val[0];
      ADDR_DATA_DIGEST: ddig_on = val[0];
      ADDR_MAX_SEG: seg_max = val[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (rx_stream.size() != 0 || rx_if.valid || due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_pdu_receive_deframer_checker_unit: errors");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_taken) begin
      if (rx_stream.size() != 0 && $urandom_range(99) >= src_idle) begin
        rx_if.data <= rx_stream.pop_front();
        rx_if.valid <= 1'b1;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) tx_if.ready <= 1'b0;
    else tx_if.ready <= $urandom_range(99) >= snk_idle;
  end

  // monitor and checker
  always @(posedge clk) begin
    rx_taken = !rst && rx_if.valid && rx_if.ready;
    if (rst) begin
      frame_restart();
    end else begin
      if (tx_if.valid && tx_if.ready) begin
        got_res = tx_if.data;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got_res));
        end else begin
          want_res = due_results.pop_front();
          if (got_res.out_byte != want_res.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h", got_res.out_byte,
                                      want_res.out_byte));
          if (got_res.byte_kind != want_res.byte_kind)
            report_mismatch($sformatf("byte_kind %0d, want %0d", got_res.byte_kind,
                                      want_res.byte_kind));
          if (got_res.unit_end != want_res.unit_end)
            report_mismatch($sformatf("unit_end %0d, want %0d", got_res.unit_end,
                                      want_res.unit_end));
          if (got_res.status != want_res.status)
            report_mismatch($sformatf("status %0d, want %0d", got_res.status,
                                      want_res.status));
          if (got_res.segment_len != want_res.segment_len)
            report_mismatch($sformatf("segment_len %h, want %h", got_res.segment_len,
                                      want_res.segment_len));
        end
      end
      if (rx_taken) begin
        if (deframe_byte(rx_if.data, next_res)) due_results.push_back(next_res);
      end
    end
  end

  initial begin
    bit phase_hd[PHASES];
    bit phase_dd[PHASES];
    logic [LEN_W-1:0] phase_max[PHASES];
    int target;
    phase_hd = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_dd = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    phase_max = '{24'd262144, 24'hFFFFFF, 24'd0, 24'd64, 24'd40, 24'hFFFFFF};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hdig_on = 1'b0;
    ddig_on = 1'b0;
    seg_max = 24'd262144;
    src_idle = 16;
    snk_idle = 63;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        repeat (8) @(posedge clk);
        reg_write(ADDR_HDR_DIGEST, {31'd0, phase_hd[p]});
        reg_write(ADDR_DATA_DIGEST, {31'd0, phase_dd[p]});
        reg_write(ADDR_MAX_SEG, {8'd0, phase_max[p]});
      end
      case (p / 2)
        0: begin
          src_idle = 16;
          snk_idle = 63;
        end
        1: begin
          src_idle = 63;
          snk_idle = 16;
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
        end
      endcase
      // register defaults: close between units, empty, pad end, no pad, too long, truncated
      if (p == 0) begin
        push_close();
        queue_unit(24'd0, 1'b0, 1'b0, 1'b0);
        queue_unit(24'd5, 1'b0, 1'b0, 1'b0);
        queue_unit(24'd8, 1'b0, 1'b0, 1'b0);
        queue_unit(24'hFFFFFF, 1'b0, 1'b0, 1'b0);
        queue_unit(24'd262145, 1'b0, 1'b0, 1'b0);
        queue_unit(24'd4, 1'b0, 1'b0, 1'b1);
      end
      // both digests: empty after good digest, bad header and data digests
      if (p == 1) begin
        queue_unit(24'd0, 1'b0, 1'b0, 1'b0);
        queue_unit(24'd1, 1'b0, 1'b0, 1'b0);
        queue_unit(24'd4, 1'b1, 1'b0, 1'b0);
        queue_unit(24'd6, 1'b0, 1'b1, 1'b0);
        queue_unit(24'd7, 1'b0, 1'b0, 1'b1);
      end
      target = queued_items + ITEMS_PER_PHASE;
      while (queued_items < target) queue_random_unit();
      push_close();
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_pdu_receive_deframer_checker_unit: clean");
    end else begin
      $display("tb_pdu_receive_deframer_checker_unit: errors");
    end
    $finish;
  end

endmodule
